>>> rtl/core/qvd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qvd_pkg: shared types and constants
// register indexes, operation codes and the serial multiplier handshake
// ----------------------------------------------------------------------------
package qvd_pkg;

	localparam int CFG_W = 24;
	localparam int IDX_W = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_ALPHA   = 3'd0,
		REG_MAXSPD  = 3'd1,
		REG_THRUST  = 3'd2,
		REG_GRAVITY = 3'd3,
		REG_DRAG    = 3'd4,
		REG_TSTEP   = 3'd5
	} reg_idx_t;

	localparam logic OP_CMD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// serial multiplier operand widths
	localparam int MA_W = 48;   // signed multiplicand
	localparam int MB_W = 25;   // unsigned multiplier, shifted out bit by bit
	localparam int MP_W = 74;   // signed product

	typedef struct packed {
		logic start;
	} mul_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/qvd_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qvd_mul: bit-serial signed by unsigned multiplier
// one multiplier bit per cycle, shift-add on a full product-width adder
// ----------------------------------------------------------------------------
module qvd_mul
	import qvd_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire mul_ctl_t               ctl,
	input  wire logic signed [MA_W-1:0] a,
	input  wire logic        [MB_W-1:0] b,
	output mul_sts_t                    sts,
	output logic signed      [MP_W-1:0] prod
);

	localparam int CNT_W = $clog2(MB_W + 1);

	logic signed [MP_W-1:0] acc_q;
	logic signed [MP_W-1:0] mcand_q;
	logic        [MB_W-1:0] mplier_q;
	logic        [CNT_W-1:0] cnt_q;
	logic                   busy_q;
	logic                   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MB_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q    <= '0;
			mcand_q  <= MP_W'(a);
			mplier_q <= b;
		end else if (busy_q) begin
			if (mplier_q[0])
				acc_q <= acc_q + mcand_q;
			mcand_q  <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign prod     = acc_q;

endmodule
`default_nettype wire

>>> rtl/core/qvd_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qvd_seq: tick sequencer
// walks the rotors and the integration steps through the shared multiplier
// ----------------------------------------------------------------------------
module qvd_seq
	import qvd_pkg::*;
#(
	parameter int ROTORS = 4
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   go,
	input  wire logic [16:0]            lag_gain,
	input  wire logic [15:0]            max_speed,
	input  wire logic [23:0]            thrust_gain,
	input  wire logic [20:0]            gravity_accel,
	input  wire logic [19:0]            drag_per_mass,
	input  wire logic [23:0]            time_step,
	input  wire logic [ROTORS*16-1:0]   cmd_flat,
	output logic                        fin,
	output logic [30:0]                 hgt_out,
	output logic signed [31:0]          vel_out,
	output logic signed [31:0]          acc_out
);

	localparam int RI_W = (ROTORS > 1) ? $clog2(ROTORS) : 1;
	// sum of squares, room for up to eight rotors
	localparam int SUM_W = 51;
	localparam int THR_W = 53;

	typedef enum logic [3:0] {
		S_IDLE, S_LAG, S_LAGW, S_SQ, S_SQW, S_TH1, S_TH1W, S_TH2, S_TH2W,
		S_DRAG, S_DRAGW, S_VEL, S_VELW, S_HGT, S_HGTW, S_DONE
	} state_t;

	state_t state_q;
	logic [RI_W-1:0] ri_q;
	logic [31:0] act_q [ROTORS];
	logic [SUM_W-1:0] sum_q;
	logic signed [THR_W-1:0] thr_q;
	logic signed [31:0] vel_q, acc_q;
	logic [31:0] hgt_q;
	logic signed [63:0] drag_q;
	logic fin_q;

	mul_ctl_t mctl;
	mul_sts_t msts;
	logic signed [MA_W-1:0] ma;
	logic [MB_W-1:0] mb;
	logic signed [MP_W-1:0] mp;

	qvd_mul u_mul (.clk(clk), .arst_n(arst_n), .ctl(mctl), .a(ma), .b(mb),
		.sts(msts), .prod(mp));

	logic [16:0] alpha_c;
	logic [31:0] cur_act;
	logic [15:0] cur_cmd;
	logic signed [33:0] diff;
	assign alpha_c = lag_gain[16] ? 17'h10000 : lag_gain;
	assign cur_act = act_q[ri_q];
	assign cur_cmd = cmd_flat[ri_q*16 +: 16];
	assign diff    = $signed({2'b00, cur_cmd, 16'h0}) - $signed({2'b00, cur_act});

	// lag result and clamp
	logic signed [MP_W-1:0] lag_d;
	logic signed [35:0] nv;
	logic [31:0] nv_c;
	logic [31:0] top;
	assign lag_d = (mp + MP_W'(33'sh8000)) >>> 16;
	assign nv    = $signed({4'b0, cur_act}) + 36'(lag_d);
	assign top   = {max_speed, 16'h0};
	always_comb begin
		if (nv < 0) nv_c = '0;
		else if (nv > $signed({4'b0, top})) nv_c = top;
		else nv_c = nv[31:0];
	end

	// velocity and height step
	logic signed [MP_W-1:0] vstep, hstep;
	logic signed [33:0] vsum;
	logic signed [31:0] vsat;
	logic signed [33:0] hsum;
	assign vstep = (mp + MP_W'(33'sh800000)) >>> 24;
	assign vsum  = 34'(vel_q) + 34'(vstep);
	assign vsat  = (vsum > 34'sh7fffffff) ? 32'sh7fffffff :
		(vsum < -34'sh80000000) ? 32'sh80000000 : vsum[31:0];
	assign hstep = vstep;
	assign hsum  = $signed({2'b0, hgt_q}) + 34'(hstep);

	// acceleration from thrust, gravity and drag
	logic signed [65:0] araw;
	logic signed [31:0] asat;
	assign araw = 66'(thr_q) - 66'($signed({1'b0, gravity_accel}))
		- 66'((drag_q + 64'sh8000) >>> 16);
	assign asat = (araw > 66'sh7fffffff) ? 32'sh7fffffff :
		(araw < -66'sh80000000) ? 32'sh80000000 : araw[31:0];

	always_comb begin
		mctl.start = 1'b0;
		ma = '0;
		mb = '0;
		case (state_q)
			S_LAG: begin
				mctl.start = 1'b1; ma = MA_W'(diff); mb = MB_W'(alpha_c);
			end
			S_SQ: begin
				mctl.start = 1'b1; ma = MA_W'({1'b0, cur_act[31:8]});
				mb = MB_W'(cur_act[31:8]);
			end
			S_TH1: begin
				mctl.start = 1'b1; ma = MA_W'({1'b0, sum_q[SUM_W-1:24]});
				mb = MB_W'(thrust_gain);
			end
			S_TH2: begin
				mctl.start = 1'b1; ma = MA_W'({1'b0, sum_q[23:0]}); mb = MB_W'(thrust_gain);
			end
			S_DRAG: begin
				mctl.start = 1'b1; ma = MA_W'(vel_q); mb = MB_W'(drag_per_mass);
			end
			S_VEL: begin
				mctl.start = 1'b1; ma = MA_W'(acc_q); mb = MB_W'(time_step);
			end
			S_HGT: begin
				mctl.start = 1'b1; ma = MA_W'(vel_q); mb = MB_W'(time_step);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ri_q    <= '0;
			fin_q   <= 1'b0;
			hgt_q   <= '0;
			vel_q   <= '0;
			acc_q   <= '0;
			sum_q   <= '0;
			thr_q   <= '0;
			drag_q  <= '0;
			for (int i = 0; i < ROTORS; i++) act_q[i] <= '0;
		end else begin
			fin_q <= 1'b0;
			case (state_q)
				S_IDLE: if (go) begin
					state_q <= S_LAG; ri_q <= '0; sum_q <= '0;
				end
				S_LAG:  state_q <= S_LAGW;
				S_LAGW: if (msts.done) begin
					act_q[ri_q] <= nv_c; state_q <= S_SQ;
				end
				S_SQ:   state_q <= S_SQW;
				S_SQW:  if (msts.done) begin
					sum_q <= sum_q + SUM_W'(mp[47:0]);
					if (ri_q == RI_W'(ROTORS - 1)) state_q <= S_TH1;
					else begin
						ri_q <= ri_q + 1'b1; state_q <= S_LAG;
					end
				end
				S_TH1:  state_q <= S_TH1W;
				S_TH1W: if (msts.done) begin
					thr_q <= mp[THR_W-1:0]; state_q <= S_TH2;
				end
				S_TH2:  state_q <= S_TH2W;
				S_TH2W: if (msts.done) begin
					thr_q <= (thr_q + THR_W'(mp[47:24])) >>> 16; state_q <= S_DRAG;
				end
				S_DRAG: state_q <= S_DRAGW;
				S_DRAGW: if (msts.done) begin
					drag_q <= mp[63:0]; state_q <= S_DONE;
				end
				S_DONE: begin
					// ground contact: resting case skips the step
					if (hgt_q == 0 && vel_q <= 0 && asat <= 0) begin
						vel_q <= '0; acc_q <= '0; fin_q <= 1'b1; state_q <= S_IDLE;
					end else begin
						acc_q <= asat; state_q <= S_VEL;
					end
				end
				S_VEL:  state_q <= S_VELW;
				S_VELW: if (msts.done) begin
					vel_q <= vsat; state_q <= S_HGT;
				end
				S_HGT:  state_q <= S_HGTW;
				S_HGTW: if (msts.done) begin
					if (hsum < 0) begin
						hgt_q <= '0; vel_q <= '0; acc_q <= '0;
					end else if (hsum > 34'sh7fffffff) hgt_q <= 32'h7fffffff;
					else hgt_q <= hsum[31:0];
					fin_q <= 1'b1; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign fin     = fin_q;
	assign hgt_out = hgt_q[30:0];
	assign vel_out = vel_q;
	assign acc_out = acc_q;

endmodule
`default_nettype wire

>>> rtl/core/quadrotor_vertical_dynamics.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadrotor_vertical_dynamics: one-axis quadrotor altitude model
// command beats store clamped rotor speeds; tick beats run the lag, thrust,
// drag and semi-implicit euler step on a bit-serial multiplier
// ----------------------------------------------------------------------------
// operation: a command beat gives no result; a tick runs a lag and a square
//   product per rotor, then thrust, drag, velocity and height products, the
//   last two skipped when resting on the ground; each serial product runs
//   issue, 25 shift-add steps, done
// flow: one item at a time; a tick blocks input until its result leaves the
//   output register
// reset: arst_n clears the control state and loads register defaults at once; result data registers are not reset
module quadrotor_vertical_dynamics
	import qvd_pkg::*;
#(
	parameter int ROTORS = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              op,
	input  wire logic [15:0]       speed_cmd_0,
	input  wire logic [15:0]       speed_cmd_1,
	input  wire logic [15:0]       speed_cmd_2,
	input  wire logic [15:0]       speed_cmd_3,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [30:0]            height,
	output logic signed [31:0]     vert_velocity,
	output logic signed [31:0]     vert_accel,
	input  wire logic              cfg_we,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data
);

	// configuration registers
	logic [16:0] alpha_q;
	logic [15:0] maxspd_q;
	logic [23:0] thrust_q;
	logic [20:0] grav_q;
	logic [19:0] drag_q;
	logic [23:0] tstep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= 17'd26214;
			maxspd_q <= 16'd10000;
			thrust_q <= 24'd103070;
			grav_q   <= 21'd642908;
			drag_q   <= 20'd9830;
			tstep_q  <= 24'd335544;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ALPHA:   alpha_q  <= cfg_data[16:0];
				REG_MAXSPD:  maxspd_q <= cfg_data[15:0];
				REG_THRUST:  thrust_q <= cfg_data[23:0];
				REG_GRAVITY: grav_q   <= cfg_data[20:0];
				REG_DRAG:    drag_q   <= cfg_data[19:0];
				REG_TSTEP:   tstep_q  <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// command store, clamped on write
	logic [ROTORS*16-1:0] cmd_q;
	logic [15:0] cmd_in [4];
	assign cmd_in[0] = speed_cmd_0;
	assign cmd_in[1] = speed_cmd_1;
	assign cmd_in[2] = speed_cmd_2;
	assign cmd_in[3] = speed_cmd_3;

	logic busy_q;
	logic in_acc;
	logic fin;
	logic [30:0] h_w;
	logic signed [31:0] v_w, a_w;

	assign in_stall = busy_q;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= '0;
		end else if (in_acc && op == OP_CMD) begin
			for (int i = 0; i < ROTORS; i++) begin
				if (i < 4)
					cmd_q[i*16 +: 16] <= (cmd_in[i] > maxspd_q) ? maxspd_q : cmd_in[i];
				else
					cmd_q[i*16 +: 16] <= '0;
			end
		end
	end

	qvd_seq #(.ROTORS(ROTORS)) u_seq (
		.clk(clk), .arst_n(arst_n), .go(in_acc && op == OP_TICK),
		.lag_gain(alpha_q), .max_speed(maxspd_q), .thrust_gain(thrust_q),
		.gravity_accel(grav_q), .drag_per_mass(drag_q), .time_step(tstep_q),
		.cmd_flat(cmd_q), .fin(fin), .hgt_out(h_w), .vel_out(v_w), .acc_out(a_w)
	);

	// busy from tick accept until its result beat leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (in_acc && op == OP_TICK) busy_q <= 1'b1;
			if (fin) out_valid <= 1'b1;
			else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
				busy_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			height        <= h_w;
			vert_velocity <= v_w;
			vert_accel    <= a_w;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/qvd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qvd_checker: port-level checks
// result held while stalled, none right after an input beat, stall while busy
// ----------------------------------------------------------------------------
module qvd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [30:0] height
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(height))
		else $error("result beat dropped while stalled");

	a_stall_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");

	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("result without busy");

	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !out_valid)
		else $error("result beat right after an input beat");

endmodule

bind quadrotor_vertical_dynamics qvd_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .height(height)
);
`default_nettype wire
